### rtl/core/rpn_pkg.sv
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic        [VALUE_WIDTH-1:0] uvalue_t;
  typedef logic        [SP_W-1:0]        sp_t;
  typedef logic        [ADDR_W-1:0]      addr_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOKEN,
    S_RD_R,
    S_RD_L,
    S_CAP_L,
    S_EXEC,
    S_RD_TOP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

### rtl/core/rpn_ram.sv
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rpn_alu.sv
module rpn_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::alu_req_t req,
  input  rpn_pkg::value_t   a,
  input  rpn_pkg::value_t   b,
  output rpn_pkg::alu_rsp_t rsp,
  output rpn_pkg::value_t   result
);
  import rpn_pkg::*;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       dz_r, dz_nxt;
  logic                       neg_r, neg_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  uvalue_t                    rem_r, rem_nxt;
  uvalue_t                    quo_r, quo_nxt;
  uvalue_t                    den_r, den_nxt;
  value_t                     res_r, res_nxt;

  uvalue_t                    mag_a, mag_b, q_step, rem_step;
  logic [VALUE_WIDTH:0]       rem_sh, diff;
  logic [2*VALUE_WIDTH-1:0]   prod;
  logic                       ge;

  always_comb begin
    mag_a    = a[VALUE_WIDTH-1] ? uvalue_t'(-a) : uvalue_t'(a);
    mag_b    = b[VALUE_WIDTH-1] ? uvalue_t'(-b) : uvalue_t'(b);
    prod     = uvalue_t'(a) * uvalue_t'(b);
    rem_sh   = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = ~diff[VALUE_WIDTH];
    q_step   = {quo_r[VALUE_WIDTH-2:0], ge};
    rem_step = ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dz_nxt   = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    res_nxt  = res_r;
    if (busy_r) begin
      rem_nxt = rem_step;
      quo_nxt = q_step;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? value_t'(-q_step) : value_t'(q_step);
      end
    end else if (req.start) begin
      case (req.op)
        OP_ADD: begin
          res_nxt  = a + b;
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          res_nxt  = a - b;
          done_nxt = 1'b1;
        end
        OP_MUL: begin
          res_nxt  = value_t'(prod[VALUE_WIDTH-1:0]);
          done_nxt = 1'b1;
        end
        OP_DIV: begin
          if (b == '0) begin
            res_nxt  = '0;
            dz_nxt   = 1'b1;
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            cnt_nxt  = CNT_W'(VALUE_WIDTH);
            rem_nxt  = '0;
            quo_nxt  = mag_a;
            den_nxt  = mag_b;
            neg_nxt  = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
          end
        end
        default: begin
          res_nxt  = '0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.div_zero = dz_r;
  assign result       = res_r;

endmodule

### rtl/core/postfix_expression_evaluator.sv
// Postfix calculator that takes one character per accepted item and keeps a stack of
// sixteen signed 32-bit values in a small RAM with a registered read port. For + - * /
// the two operands are popped one after the other through the single read port before
// the shared arithmetic unit runs. The shared unit divides magnitudes one quotient bit
// per cycle; a / with a zero divisor gives zero without dividing. The character marked
// last also closes any open token and has the top of stack read for the result.
// The result is held in an output register, so the block goes on taking characters while
// it waits; a second result waits in the sequencer until the first has been taken.
module postfix_expression_evaluator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_char_code,
  input  logic            in_end_of_expr,
  output logic            out_valid,
  input  logic            out_stall,
  output rpn_pkg::value_t out_top_value,
  output rpn_pkg::sp_t    out_stack_count,
  output logic            out_divide_by_zero,
  output logic            out_stack_overflow
);
  import rpn_pkg::*;

  state_t   state_r, state_nxt;
  sp_t      sp_r, sp_nxt;
  uvalue_t  acc_r, acc_nxt;
  logic     in_tok_r, in_tok_nxt;
  logic     dstop_r, dstop_nxt;
  logic     dz_seen_r, dz_seen_nxt;
  logic     ov_seen_r, ov_seen_nxt;
  logic     last_r, last_nxt;
  logic     is_op_r, is_op_nxt;
  alu_op_t  op_r, op_nxt;
  logic     rd_ok_r, rd_ok_nxt;
  value_t   right_r, right_nxt;
  logic     out_valid_r, out_valid_nxt;
  value_t   out_top_r, out_top_nxt;
  sp_t      out_count_r, out_count_nxt;
  logic     out_dz_r, out_dz_nxt;
  logic     out_ov_r, out_ov_nxt;

  logic     ram_we;
  addr_t    ram_waddr, ram_raddr;
  value_t   ram_wdata, rd_data;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  value_t   alu_a, alu_result;

  sp_t      sp_m1;
  logic     push_ok, is_op, is_space, is_digit, out_free;
  uvalue_t  base;
  logic     stop;

  rpn_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (alu_a),
    .b      (right_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_comb begin
    sp_m1    = sp_r - SP_W'(1);
    push_ok  = sp_r < SP_W'(STACK_DEPTH);
    is_op    = in_char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    is_space = in_char_code == CH_SPACE;
    is_digit = in_char_code inside {[CH_ZERO:CH_NINE]};
    out_free = !out_valid_r || !out_stall;
    base     = in_tok_r ? acc_r : '0;
    stop     = in_tok_r && dstop_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_op || is_space || in_end_of_expr) begin
            state_nxt = S_TOKEN;
          end
        end
      end
      S_TOKEN: begin
        if (is_op_r) begin
          state_nxt = S_RD_R;
        end else if (last_r) begin
          state_nxt = S_RD_TOP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_R:  state_nxt = S_RD_L;
      S_RD_L:  state_nxt = S_CAP_L;
      S_CAP_L: state_nxt = S_EXEC;
      S_EXEC: begin
        if (alu_rsp.done) begin
          state_nxt = last_r ? S_RD_TOP : S_IDLE;
        end
      end
      S_RD_TOP: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sp_nxt        = sp_r;
    acc_nxt       = acc_r;
    in_tok_nxt    = in_tok_r;
    dstop_nxt     = dstop_r;
    dz_seen_nxt   = dz_seen_r;
    ov_seen_nxt   = ov_seen_r;
    last_nxt      = last_r;
    is_op_nxt     = is_op_r;
    op_nxt        = op_r;
    rd_ok_nxt     = rd_ok_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_top_nxt   = out_top_r;
    out_count_nxt = out_count_r;
    out_dz_nxt    = out_dz_r;
    out_ov_nxt    = out_ov_r;
    ram_we        = 1'b0;
    ram_waddr     = sp_r[ADDR_W-1:0];
    ram_wdata     = value_t'(acc_r);
    ram_raddr     = sp_m1[ADDR_W-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    alu_a         = rd_ok_r ? rd_data : '0;
    in_stall      = state_r != S_IDLE;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt  = in_end_of_expr;
          is_op_nxt = is_op;
          case (in_char_code)
            CH_PLUS:  op_nxt = OP_ADD;
            CH_MINUS: op_nxt = OP_SUB;
            CH_STAR:  op_nxt = OP_MUL;
            CH_SLASH: op_nxt = OP_DIV;
            default:  op_nxt = op_r;
          endcase
          if (!is_op && !is_space) begin
            in_tok_nxt = 1'b1;
            if (is_digit && !stop) begin
              acc_nxt   = (base << 3) + (base << 1)
                        + uvalue_t'(in_char_code - CH_ZERO);
              dstop_nxt = 1'b0;
            end else begin
              acc_nxt   = base;
              dstop_nxt = 1'b1;
            end
          end
        end
      end
      S_TOKEN: begin
        if (in_tok_r) begin
          in_tok_nxt = 1'b0;
          dstop_nxt  = 1'b0;
          acc_nxt    = '0;
          if (push_ok) begin
            ram_we = 1'b1;
            sp_nxt = sp_r + SP_W'(1);
          end else begin
            ov_seen_nxt = 1'b1;
          end
        end
      end
      S_RD_R: begin
        rd_ok_nxt = sp_r != '0;
        if (sp_r != '0) begin
          sp_nxt = sp_m1;
        end
      end
      S_RD_L: begin
        right_nxt = rd_ok_r ? rd_data : '0;
        rd_ok_nxt = sp_r != '0;
        if (sp_r != '0) begin
          sp_nxt = sp_m1;
        end
      end
      S_CAP_L: begin
        alu_req.start = 1'b1;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          ram_wdata = alu_result;
          if (alu_rsp.div_zero) begin
            dz_seen_nxt = 1'b1;
          end
          if (push_ok) begin
            ram_we = 1'b1;
            sp_nxt = sp_r + SP_W'(1);
          end else begin
            ov_seen_nxt = 1'b1;
          end
        end
      end
      S_RD_TOP: begin
        rd_ok_nxt = sp_r != '0;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = rd_ok_r ? rd_data : '0;
          out_count_nxt = sp_r;
          out_dz_nxt    = dz_seen_r;
          out_ov_nxt    = ov_seen_r;
          dz_seen_nxt   = 1'b0;
          ov_seen_nxt   = 1'b0;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      acc_r       <= '0;
      in_tok_r    <= 1'b0;
      dstop_r     <= 1'b0;
      dz_seen_r   <= 1'b0;
      ov_seen_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
      in_tok_r    <= in_tok_nxt;
      dstop_r     <= dstop_nxt;
      dz_seen_r   <= dz_seen_nxt;
      ov_seen_r   <= ov_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    is_op_r     <= is_op_nxt;
    op_r        <= op_nxt;
    rd_ok_r     <= rd_ok_nxt;
    right_r     <= right_nxt;
    out_top_r   <= out_top_nxt;
    out_count_r <= out_count_nxt;
    out_dz_r    <= out_dz_nxt;
    out_ov_r    <= out_ov_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_top_value      = out_top_r;
  assign out_stack_count    = out_count_r;
  assign out_divide_by_zero = out_dz_r;
  assign out_stack_overflow = out_ov_r;

endmodule

### rtl/core/rpn_checker.sv
module rpn_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic [7:0]      in_char_code,
  input logic            in_end_of_expr,
  input logic            out_valid,
  input logic            out_stall,
  input rpn_pkg::value_t out_top_value,
  input rpn_pkg::sp_t    out_stack_count,
  input logic            out_divide_by_zero,
  input logic            out_stack_overflow
);
  import rpn_pkg::*;

  logic in_acc, ends_token;

  assign in_acc     = in_valid && !in_stall;
  assign ends_token = (in_char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_SPACE})
                   || in_end_of_expr;

  // A space, an operator or the final character always needs further cycles.
  a_busy_after_token_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ends_token |=> in_stall)
    else $error("block took a new item straight after a token end");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stack_count <= SP_W'(STACK_DEPTH))
    else $error("reported stack depth exceeds the stack size");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_count == '0 |-> out_top_value == '0)
    else $error("empty stack reported a non-zero top value");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_value)
      && $stable(out_stack_count) && $stable(out_divide_by_zero)
      && $stable(out_stack_overflow))
    else $error("stalled result changed");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (.*);

### dv/tb_postfix_expression_evaluator.sv
module tb_postfix_expression_evaluator;
  import rpn_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    value_t top;
    sp_t    count;
    logic   div_zero;
    logic   overflow;
  } calc_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_of_expr;
  logic       out_valid;
  logic       out_stall;
  value_t     out_top_value;
  sp_t        out_stack_count;
  logic       out_divide_by_zero;
  logic       out_stack_overflow;

  postfix_expression_evaluator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_end_of_expr    (in_end_of_expr),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_top_value     (out_top_value),
    .out_stack_count   (out_stack_count),
    .out_divide_by_zero(out_divide_by_zero),
    .out_stack_overflow(out_stack_overflow)
  );

  // Predicted calculator state.
  value_t  calc_stack [STACK_DEPTH];
  int      calc_sp;
  uvalue_t tok_acc;
  bit      tok_open;
  bit      tok_stopped;
  bit      div_zero_flag;
  bit      overflow_flag;

  calc_result_t expected_results[$];
  logic [7:0]   expr_chars[$];

  int  errors;
  int  chars_sent;
  int  results_checked;
  int  div_zero_results;
  int  overflow_results;
  int  quiet_cycles;
  bit  tx_idling;
  bit  rx_idling;
  int  rx_hold_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void calc_push(value_t v);
    if (calc_sp >= STACK_DEPTH) begin
      overflow_flag = 1'b1;
    end else begin
      calc_stack[calc_sp] = v;
      calc_sp++;
    end
  endfunction

  function automatic value_t calc_pop();
    if (calc_sp == 0) return '0;
    calc_sp--;
    return calc_stack[calc_sp];
  endfunction

  function automatic value_t calc_divide(value_t lhs, value_t rhs);
    uvalue_t mag_l;
    uvalue_t mag_r;
    uvalue_t quo;
    if (rhs == '0) begin
      div_zero_flag = 1'b1;
      return '0;
    end
    mag_l = lhs[VALUE_WIDTH-1] ? uvalue_t'(-lhs) : uvalue_t'(lhs);
    mag_r = rhs[VALUE_WIDTH-1] ? uvalue_t'(-rhs) : uvalue_t'(rhs);
    quo   = mag_l / mag_r;
    return (lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1]) ? value_t'(-quo) : value_t'(quo);
  endfunction

  function automatic void close_token();
    if (tok_open) begin
      calc_push(value_t'(tok_acc));
      tok_open    = 1'b0;
      tok_stopped = 1'b0;
      tok_acc     = '0;
    end
  endfunction

  function automatic void predict_char(logic [7:0] ch, logic last);
    value_t       rhs;
    value_t       lhs;
    value_t       res;
    calc_result_t r;
    case (ch)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
        close_token();
        rhs = calc_pop();
        lhs = calc_pop();
        case (ch)
          CH_PLUS:  res = lhs + rhs;
          CH_MINUS: res = lhs - rhs;
          CH_STAR:  res = lhs * rhs;
          default:  res = calc_divide(lhs, rhs);
        endcase
        calc_push(res);
      end
      CH_SPACE: close_token();
      default: begin
        if (!tok_open) begin
          tok_open    = 1'b1;
          tok_stopped = 1'b0;
          tok_acc     = '0;
        end
        if ((ch inside {[CH_ZERO:CH_NINE]}) && !tok_stopped) begin
          tok_acc = tok_acc * 10 + (ch - CH_ZERO);
        end else begin
          tok_stopped = 1'b1;
        end
      end
    endcase
    if (last) begin
      close_token();
      r.top      = (calc_sp > 0) ? calc_stack[calc_sp-1] : '0;
      r.count    = sp_t'(calc_sp);
      r.div_zero = div_zero_flag;
      r.overflow = overflow_flag;
      if (div_zero_flag) div_zero_results++;
      if (overflow_flag) overflow_results++;
      expected_results.push_back(r);
      div_zero_flag = 1'b0;
      overflow_flag = 1'b0;
    end
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_char_code   = ch;
    in_end_of_expr = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(ch, last);
    chars_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_chars.size(); i++) begin
      send_char(expr_chars[i], i == expr_chars.size() - 1);
    end
    expr_chars.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_token_char();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while (ch inside {CH_SPACE, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
    return ch;
  endfunction

  task automatic add_operand();
    int         kind;
    logic [7:0] first;
    kind = $urandom_range(0, 11);
    case (kind)
      0: add_text("0");
      1: begin
        for (int i = 0; i < 10; i++) begin
          expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      2: begin
        do begin
          first = rand_token_char();
        end while (first inside {[CH_ZERO:CH_NINE]});
        expr_chars.push_back(first);
        repeat ($urandom_range(0, 3)) expr_chars.push_back(rand_token_char());
      end
      3: begin
        add_text($sformatf("%0d", $urandom_range(0, 99)));
        expr_chars.push_back(rand_token_char());
        add_text($sformatf("%0d", $urandom_range(0, 99)));
      end
      4: add_text($sformatf("%0d", $urandom_range(1, 9)));
      default: add_text($sformatf("%0d", $urandom_range(0, 999)));
    endcase
  endtask

  task automatic add_operator();
    if ($urandom_range(0, 2) == 0) expr_chars.push_back(CH_SPACE);
    case ($urandom_range(0, 3))
      0: expr_chars.push_back(CH_PLUS);
      1: expr_chars.push_back(CH_MINUS);
      2: expr_chars.push_back(CH_STAR);
      default: expr_chars.push_back(CH_SLASH);
    endcase
  endtask

  // Mostly balanced expressions; extra operators keep the stack from
  // sitting full and now and then pop an empty stack.
  task automatic add_random_expr();
    int operands;
    int pending;
    int extra;
    bit prev_operand;
    operands     = $urandom_range(1, 5);
    pending      = 0;
    prev_operand = 1'b0;
    for (int i = 0; i < operands; i++) begin
      if (prev_operand || $urandom_range(0, 3) == 0) begin
        expr_chars.push_back(CH_SPACE);
        if ($urandom_range(0, 4) == 0) expr_chars.push_back(CH_SPACE);
      end
      add_operand();
      prev_operand = 1'b1;
      pending++;
      while (pending > 1 && $urandom_range(0, 1) == 0) begin
        add_operator();
        pending--;
        prev_operand = 1'b0;
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      while (pending > 1) begin
        add_operator();
        pending--;
      end
    end
    extra = 0;
    if (calc_sp + pending > 12) extra = $urandom_range(2, 6);
    else if ($urandom_range(0, 5) == 0) extra = $urandom_range(1, 3);
    repeat (extra) add_operator();
    if ($urandom_range(0, 5) == 0) expr_chars.push_back(CH_SPACE);
  endtask

  task automatic run_random_exprs(input int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      add_random_expr();
      send_expr();
    end
  endtask

  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    // Operator on an empty stack, dividing zero by zero.
    add_text("/");
    send_expr();
    // Number that wraps to the most negative value, then divided by minus one.
    add_text("6442450944 0 1-/");
    send_expr();
    // Digit run stopped by a letter and by 8'hFF; product overflows.
    add_text("7a9");
    expr_chars.push_back(8'hFF);
    add_text("*");
    send_expr();
    // Token led by a non-digit, operand order and truncation toward zero.
    expr_chars.push_back(8'h00);
    add_text(" 7-2/");
    send_expr();
    // Filling the stack past its depth; last digit closes the final token.
    add_text("9 9 9 9 9 9 9 9 9 9 9 9 9 9");
    send_expr();
    wait_results_drained();
  endtask

  task automatic test_random_exprs();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    run_random_exprs(1050);
  endtask

  task automatic test_noise();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    repeat (250) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_back_pressure();
    wait_results_drained();
    tx_idling      = 1'b0;
    rx_idling      = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    run_random_exprs(100);
    while (rx_hold_cycles > 0) @(negedge clk);
  endtask

  task automatic test_drain_pause();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    repeat (8) begin
      run_random_exprs($urandom_range(10, 25));
      wait_results_drained();
    end
  endtask

  task automatic test_full_rate();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    run_random_exprs(250);
  endtask

  initial begin : rx_drive
    int   burst_left;
    logic burst_level;
    burst_left  = 0;
    burst_level = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall = 1'b1;
        rx_hold_cycles--;
      end else if (!rx_idling) begin
        out_stall  = 1'b0;
        burst_left = 0;
      end else begin
        if (burst_left == 0) begin
          burst_level = ($urandom_range(0, 2) == 0);
          burst_left  = $urandom_range(1, 19);
        end
        out_stall = burst_level;
        burst_left--;
      end
    end
  end

  always @(posedge clk) begin : check_result
    calc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: top_value %0d, stack_count %0d",
               out_top_value, out_stack_count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_top_value !== want.top) begin
          $error("top_value: expected %0d, got %0d", want.top, out_top_value);
          errors++;
        end
        if (out_stack_count !== want.count) begin
          $error("stack_count: expected %0d, got %0d", want.count, out_stack_count);
          errors++;
        end
        if (out_divide_by_zero !== want.div_zero) begin
          $error("divide_by_zero: expected %0b, got %0b", want.div_zero, out_divide_by_zero);
          errors++;
        end
        if (out_stack_overflow !== want.overflow) begin
          $error("stack_overflow: expected %0b, got %0b", want.overflow, out_stack_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[postfix_expression_evaluator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = 8'h00;
    in_end_of_expr = 1'b0;
    tx_idling      = 1'b0;
    rx_idling      = 1'b0;
    rx_hold_cycles = 0;
    errors         = 0;
    calc_sp        = 0;
    tok_acc        = '0;
    tok_open       = 1'b0;
    tok_stopped    = 1'b0;
    div_zero_flag  = 1'b0;
    overflow_flag  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_exprs();
    test_noise();
    test_back_pressure();
    test_drain_pause();
    test_full_rate();

    wait_results_drained();
    repeat (80) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Sent %0d characters and checked %0d results, %0d with divide by zero",
             chars_sent, results_checked, div_zero_results);
    $display("and %0d with a dropped push, under random and held-off flow control.",
             overflow_results);
    if (errors == 0) begin
      $display("[postfix_expression_evaluator] OK");
    end else begin
      $display("[postfix_expression_evaluator] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_ram.sv
rtl/core/rpn_alu.sv
rtl/core/postfix_expression_evaluator.sv
rtl/core/rpn_checker.sv
dv/tb_postfix_expression_evaluator.sv
